// File: design/bate_pkg.sv
// ----------------------------------------------------------------------------
// bate_pkg
// Types, operation codes and status codes of the bounded array table engine.
// ----------------------------------------------------------------------------
package bate_pkg;

   typedef enum logic [4:0] {
      FN_CLEAR    = 5'd0,
      FN_APPEND   = 5'd1,
      FN_SORTASC  = 5'd2,
      FN_SORTDESC = 5'd3,
      FN_INSASC   = 5'd4,
      FN_INSDESC  = 5'd5,
      FN_INSAT    = 5'd6,
      FN_DELETE   = 5'd7,
      FN_SEARCH   = 5'd8,
      FN_READ     = 5'd9,
      FN_SET      = 5'd10,
      FN_MAX      = 5'd11,
      FN_MIN      = 5'd12,
      FN_SUM      = 5'd13,
      FN_AVG      = 5'd14,
      FN_REVERSE  = 5'd15,
      FN_ROTATE   = 5'd16
   } func_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BADPOS   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam int FUNC_W = 5;
   localparam int OPND_W = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 3;
   localparam int IDX_W  = 6;
   localparam int DATA_W = 38;
   localparam int CNT_W  = 7;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SORT_RDI,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_WRJ,
      S_REV_RDA,
      S_REV_RDB,
      S_REV_WRA,
      S_REV_WRB,
      S_DIV,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic                negative;
      logic [DATA_W-1:0]   dividend;
      logic [CNT_W-1:0]    divisor;
   } div_req_type;

endpackage

// File: design/bate_div.sv
// ----------------------------------------------------------------------------
// bate_div
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module bate_div (
   input  logic                       clock,
   input  logic                       reset,
   input  bate_pkg::div_req_type      req,
   output logic                       done,
   output logic [bate_pkg::DATA_W-1:0] quotient
);
   import bate_pkg::*;

   localparam int STEPS_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]   dvs_ff, dvs_in;
   logic [STEPS_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [CNT_W:0]     trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CNT_W-1:0], quo_ff[DATA_W-1]};
      if (req.start) begin
         quo_in  = req.negative ? (~req.dividend + 1'b1) : req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = STEPS_W'(DATA_W);
         busy_in = 1'b1;
         neg_in  = req.negative;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEPS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule

// File: design/bate_mem.sv
// ----------------------------------------------------------------------------
// bate_mem
// Single-port table memory with registered read data.
// ----------------------------------------------------------------------------
module bate_mem #(
   parameter int DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [VALUE_WIDTH-1:0]   wr_data,
   output logic [VALUE_WIDTH-1:0]   rd_data
);
   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;
endmodule

// File: design/bounded_array_table_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_table_engine
// Packed array of signed words with insert, delete, search, sort and reductions.
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// req      in         valid / stall  func, operand_value, position
// rsp      out        valid / stall  status, found_index, data_out, counts
// csr      in         valid / ready  capacity
//
// one transaction at a time; a scan walks the table through one memory port,
// reading then comparing each slot; shifts read then write each moved slot,
// sort compares pairs and writes both slots on a swap, average runs the
// divider after the sum. reset is synchronous and clears count, capacity (to
// 64) and control; table contents are undefined. the result register holds
// under rsp_stall; req_stall is high while busy or while a response is valid.
// ----------------------------------------------------------------------------
module bounded_array_table_engine #(
   parameter int DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bate_pkg::FUNC_W-1:0]   req_func,
   input  logic signed [bate_pkg::OPND_W-1:0] req_operand_value,
   input  logic [bate_pkg::POS_W-1:0]    req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bate_pkg::STAT_W-1:0]   rsp_status,
   output logic [bate_pkg::IDX_W-1:0]    rsp_found_index,
   output logic signed [bate_pkg::DATA_W-1:0] rsp_data_out,
   output logic [bate_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic [bate_pkg::CNT_W-1:0]    rsp_free_slots,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bate_pkg::CNT_W-1:0]    csr_capacity
);
   import bate_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in;
   logic [NW-1:0] pos_ff, pos_in, idx_ff, idx_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [4:0]  fn_ff, fn_in;
   logic signed [VALUE_WIDTH-1:0] v_ff, v_in, a_ff, a_in, b_ff, b_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic rv_ff, rv_in;
   logic [STAT_W-1:0] ost_ff, ost_in;
   logic [IDX_W-1:0]  oidx_ff, oidx_in;
   logic signed [DATA_W-1:0] odat_ff, odat_in;
   logic [CNT_W-1:0]  ocnt_ff, ocnt_in, ofree_ff, ofree_in;

   logic [AW-1:0] m_addr;
   logic m_we;
   logic signed [VALUE_WIDTH-1:0] m_wd, m_rd;
   div_req_type dreq;
   logic d_done;
   logic [DATA_W-1:0] d_q;

   logic [NW-1:0] ecap;
   logic full, accept, swap, mv_up, ins_stop;
   logic [NW:0] free_w;

   bate_mem #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
      .clock(clock), .addr(m_addr), .wr_en(m_we), .wr_data(m_wd), .rd_data(m_rd)
   );

   bate_div u_div (
      .clock(clock), .reset(reset), .req(dreq), .done(d_done), .quotient(d_q)
   );

   assign ecap = ({1'b0, cap_ff} > (CNT_W+1)'(DEPTH)) ? NW'(DEPTH) : NW'(cap_ff);
   assign full = count_ff >= ecap;
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign accept = req_valid && !req_stall;
   assign csr_ready = (state_ff == S_IDLE);
   assign free_w = (ecap > count_ff) ? {1'b0, ecap - count_ff} : '0;
   assign swap = (fn_ff == 5'(FN_SORTDESC)) ? (m_rd > a_ff) : (m_rd < a_ff);
   assign mv_up = (fn_ff == 5'(FN_DELETE)) || (fn_ff == 5'(FN_ROTATE));
   assign ins_stop = (fn_ff == 5'(FN_INSASC) && !(m_rd > v_ff)) ||
                     (fn_ff == 5'(FN_INSDESC) && !(m_rd < v_ff));

   // memory port and divider controls
   always_comb begin
      m_addr = i_ff[AW-1:0]; m_we = 1'b0; m_wd = a_ff;
      dreq = '0;
      dreq.dividend = acc_ff + DATA_W'(m_rd);
      dreq.negative = dreq.dividend[DATA_W-1];
      dreq.divisor = CNT_W'(count_ff);
      case (state_ff)
         S_SCAN_CMP: begin
            if (fn_ff == 5'(FN_AVG) && i_ff + 1'b1 >= count_ff) dreq.start = 1'b1;
         end
         S_SHIFT_RD: begin
            if (!mv_up) m_addr = AW'(i_ff - 1'b1);
         end
         S_SHIFT_WR: begin
            if (mv_up) begin
               m_addr = AW'(i_ff - 1'b1); m_we = 1'b1; m_wd = m_rd;
            end else if (!ins_stop) begin
               m_we = 1'b1; m_wd = m_rd;
            end
         end
         S_WRITE: m_we = 1'b1;
         S_SORT_RDJ: m_addr = j_ff[AW-1:0];
         S_SORT_CMP: begin
            if (swap) begin
               m_we = 1'b1; m_wd = m_rd;
            end else m_addr = AW'(j_ff + 1'b1);
         end
         S_SORT_WRJ: begin
            m_addr = j_ff[AW-1:0]; m_we = 1'b1; m_wd = a_ff;
         end
         S_REV_RDB: m_addr = j_ff[AW-1:0];
         S_REV_WRA: begin
            m_we = 1'b1; m_wd = m_rd;
         end
         S_REV_WRB: begin
            m_addr = j_ff[AW-1:0]; m_we = 1'b1; m_wd = a_ff;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff; i_in = i_ff; j_in = j_ff;
      pos_in = pos_ff; idx_in = idx_ff; cap_in = cap_ff; fn_in = fn_ff;
      v_in = v_ff; a_in = a_ff; b_in = b_ff; acc_in = acc_ff; st_in = st_ff;
      rv_in = rv_ff && rsp_stall;
      ost_in = ost_ff; oidx_in = oidx_ff; odat_in = odat_ff;
      ocnt_in = ocnt_ff; ofree_in = ofree_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fn_in = req_func;
               v_in = VALUE_WIDTH'(req_operand_value);
               pos_in = (int'(req_position) > DEPTH) ? '0 : NW'(req_position);
               st_in = ST_OK; idx_in = '0; acc_in = '0;
               i_in = '0; state_in = S_DONE;
               case (req_func)
                  5'(FN_CLEAR): count_in = '0;
                  5'(FN_APPEND): begin
                     if (full) st_in = ST_FULL;
                     else begin
                        i_in = count_ff; idx_in = count_ff;
                        a_in = VALUE_WIDTH'(req_operand_value);
                        state_in = S_WRITE;
                     end
                  end
                  5'(FN_SORTASC), 5'(FN_SORTDESC): begin
                     if (count_ff > NW'(1)) state_in = S_SORT_RDI;
                  end
                  5'(FN_INSASC), 5'(FN_INSDESC): begin
                     if (full) st_in = ST_FULL;
                     else begin
                        i_in = count_ff; state_in = S_SHIFT_RD;
                     end
                  end
                  5'(FN_INSAT): begin
                     if ({1'b0, req_position} > (POS_W+1)'(count_ff)) st_in = ST_BADPOS;
                     else if (full) st_in = ST_FULL;
                     else begin
                        i_in = count_ff; state_in = S_SHIFT_RD;
                     end
                  end
                  5'(FN_DELETE), 5'(FN_SEARCH), 5'(FN_MAX), 5'(FN_MIN),
                  5'(FN_SUM), 5'(FN_AVG): begin
                     if (count_ff == '0) begin
                        if (req_func == 5'(FN_SEARCH)) st_in = ST_NOTFOUND;
                        else if (req_func != 5'(FN_SUM)) st_in = ST_EMPTY;
                     end else state_in = S_SCAN_RD;
                  end
                  5'(FN_READ), 5'(FN_SET): begin
                     if ({1'b0, req_position} >= (POS_W+1)'(count_ff)) st_in = ST_BADPOS;
                     else begin
                        i_in = NW'(req_position); idx_in = NW'(req_position);
                        a_in = VALUE_WIDTH'(req_operand_value);
                        state_in = (req_func == 5'(FN_SET)) ? S_WRITE : S_SCAN_RD;
                     end
                  end
                  5'(FN_REVERSE): begin
                     if (count_ff > NW'(1)) begin
                        j_in = count_ff - 1'b1; state_in = S_REV_RDA;
                     end
                  end
                  5'(FN_ROTATE): begin
                     if (count_ff > NW'(1)) begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            state_in = S_SCAN_RD;
            i_in = i_ff + 1'b1;
            case (fn_ff)
               5'(FN_READ): begin
                  acc_in = DATA_W'(m_rd); state_in = S_DONE;
               end
               5'(FN_ROTATE): begin
                  // rotate reuses delete shift from slot zero
                  a_in = m_rd; state_in = S_SHIFT_RD; i_in = NW'(1);
               end
               5'(FN_DELETE), 5'(FN_SEARCH): begin
                  if (m_rd == v_ff) begin
                     idx_in = i_ff;
                     if (fn_ff == 5'(FN_SEARCH)) state_in = S_DONE;
                     else begin
                        i_in = i_ff + 1'b1; state_in = S_SHIFT_RD;
                     end
                  end else if (i_ff + 1'b1 >= count_ff) begin
                     st_in = ST_NOTFOUND; state_in = S_DONE;
                  end
               end
               5'(FN_MAX), 5'(FN_MIN): begin
                  if (i_ff == '0 ||
                      ((fn_ff == 5'(FN_MAX)) ? (DATA_W'(m_rd) > acc_ff)
                                             : (DATA_W'(m_rd) < acc_ff))) begin
                     acc_in = DATA_W'(m_rd); idx_in = i_ff;
                  end
                  if (i_ff + 1'b1 >= count_ff) state_in = S_DONE;
               end
               default: begin
                  acc_in = acc_ff + DATA_W'(m_rd);
                  if (i_ff + 1'b1 >= count_ff) begin
                     if (fn_ff == 5'(FN_AVG)) state_in = S_DIV;
                     else state_in = S_DONE;
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            // inserts move down from the top, delete and rotate move up
            if (mv_up) begin
               if (i_ff >= count_ff) begin
                  i_in = count_ff - 1'b1;
                  if (fn_ff == 5'(FN_DELETE)) begin
                     count_in = count_ff - 1'b1; state_in = S_DONE;
                  end else state_in = S_WRITE;
               end else state_in = S_SHIFT_WR;
            end else begin
               if (i_ff == '0 || (fn_ff == 5'(FN_INSAT) && i_ff == pos_ff)) begin
                  a_in = v_ff; idx_in = i_ff; state_in = S_WRITE;
               end else state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            if (mv_up) begin
               i_in = i_ff + 1'b1; state_in = S_SHIFT_RD;
            end else if (ins_stop) begin
               a_in = v_ff; idx_in = i_ff; state_in = S_WRITE;
            end else begin
               i_in = i_ff - 1'b1; state_in = S_SHIFT_RD;
            end
         end
         S_WRITE: begin
            if (fn_ff == 5'(FN_ROTATE)) idx_in = '0;
            else if (fn_ff != 5'(FN_SET)) count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_SORT_RDI: begin
            j_in = i_ff + 1'b1; state_in = S_SORT_RDJ;
         end
         S_SORT_RDJ: begin
            a_in = m_rd; state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            b_in = m_rd;
            if (swap) begin
               state_in = S_SORT_WRJ;
            end else if (j_ff + 1'b1 >= count_ff) begin
               if (i_ff + NW'(2) >= count_ff) state_in = S_DONE;
               else begin
                  i_in = i_ff + 1'b1; state_in = S_SORT_RDI;
               end
            end else begin
               j_in = j_ff + 1'b1; state_in = S_SORT_CMP;
            end
         end
         S_SORT_WRJ: begin
            a_in = b_ff;
            if (j_ff + 1'b1 >= count_ff) begin
               if (i_ff + NW'(2) >= count_ff) state_in = S_DONE;
               else begin
                  i_in = i_ff + 1'b1; state_in = S_SORT_RDI;
               end
            end else begin
               j_in = j_ff + 1'b1; state_in = S_REV_RDB;
            end
         end
         S_REV_RDA: begin
            state_in = S_REV_RDB;
         end
         S_REV_RDB: begin
            if (fn_ff == 5'(FN_REVERSE)) begin
               a_in = m_rd; state_in = S_REV_WRA;
            end else begin
               // sort: a already holds slot i, slot j is being fetched
               state_in = S_SORT_CMP;
            end
         end
         S_REV_WRA: begin
            state_in = S_REV_WRB;
         end
         S_REV_WRB: begin
            if (i_ff + NW'(2) >= j_ff) state_in = S_DONE;
            else begin
               i_in = i_ff + 1'b1; j_in = j_ff - 1'b1; state_in = S_REV_RDA;
            end
         end
         S_DIV: begin
            if (d_done) begin
               acc_in = d_q; state_in = S_DONE;
            end
         end
         S_DONE: begin
            rv_in = 1'b1;
            ost_in = st_ff;
            oidx_in = (st_ff == ST_OK || fn_ff == 5'(FN_DELETE) && st_ff == ST_OK)
                      ? IDX_W'(idx_ff) : '0;
            odat_in = (st_ff == ST_OK) ? acc_ff : '0;
            if (!(fn_ff == 5'(FN_READ) || fn_ff == 5'(FN_MAX) || fn_ff == 5'(FN_MIN) ||
                  fn_ff == 5'(FN_SUM) || fn_ff == 5'(FN_AVG))) odat_in = '0;
            if (fn_ff == 5'(FN_SUM) || fn_ff == 5'(FN_AVG) || fn_ff == 5'(FN_SORTASC) ||
                fn_ff == 5'(FN_SORTDESC) || fn_ff == 5'(FN_REVERSE) ||
                fn_ff == 5'(FN_ROTATE) || fn_ff == 5'(FN_CLEAR)) oidx_in = '0;
            ocnt_in = CNT_W'(count_ff);
            ofree_in = CNT_W'(free_w);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cap_ff <= CNT_W'(64);
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cap_ff <= cap_in;
         rv_ff <= rv_in;
      end
      i_ff <= i_in; j_ff <= j_in; pos_ff <= pos_in;
      idx_ff <= idx_in; fn_ff <= fn_in; v_ff <= v_in; a_ff <= a_in; b_ff <= b_in;
      acc_ff <= acc_in; st_ff <= st_in;
      ost_ff <= ost_in; oidx_ff <= oidx_in; odat_ff <= odat_in;
      ocnt_ff <= ocnt_in; ofree_ff <= ofree_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = ost_ff;
   assign rsp_found_index = oidx_ff;
   assign rsp_data_out    = odat_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_free_slots  = ofree_ff;
endmodule
